// ----- rtl/fmrx_pkg.sv -----
// Shared types, constants and arithmetic helpers for the FM receive audio filter.
// Used by fmrx_mac and fm_rx_audio_unpack_filter; depends on nothing else.
package fmrx_pkg;

    // Sequencer states of the filter engine
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN_MUL,
        ST_GAIN_SAT,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_SCALE_MUL,
        ST_SCALE_SAT,
        ST_OUT
    } seq_state_t;

    // Control word for the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;    // load the product register
        logic acc_en;    // fold this product into the accumulator
        logic acc_load;  // first term: load instead of add
    } mac_ctrl_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_RX_GAIN   = 1'b0;
    localparam logic [0:0] CFG_DEEMPH_EN = 1'b1;

    localparam logic [15:0] RX_GAIN_RESET = 16'd4096;

    // Filter shape
    localparam int DE_TERMS = 3;
    localparam int BQ_TERMS = 5;
    localparam int BQ_ROWS  = 3;

    // Q28 linear gains
    localparam logic signed [31:0] DEEMPH_GAIN = 32'sd674279380;
    localparam logic signed [31:0] STAGE_GAIN  = 32'sd337940217;

    // Rounding offset for a right shift by 28
    localparam logic signed [63:0] ROUND_HALF_Q28 = 64'sd134217728;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // De-emphasis coefficients, feedback term already negated: b0, b1, -a1
    function automatic logic signed [31:0] de_coef(input logic [2:0] k);
        logic signed [31:0] c;
        unique case (k)
            3'd0:    c = 32'sd20693118;
            3'd1:    c = 32'sd20693118;
            3'd2:    c = 32'sd227049220;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Biquad coefficients per row, feedback terms negated: b0, b1, b2, -a1, -a2
    function automatic logic signed [31:0] bq_coef(input logic [1:0] row,
                                                   input logic [2:0] k);
        logic signed [31:0] c;
        c = '0;
        unique case (row)
            2'd0:
            begin
                unique case (k)
                    3'd0:    c = 32'sd79175113;
                    3'd1:    c = 32'sd0;
                    3'd2:    c = -32'sd79175113;
                    3'd3:    c = 32'sd164778095;
                    3'd4:    c = 32'sd15343413;
                    default: c = '0;
                endcase
            end
            2'd1:
            begin
                unique case (k)
                    3'd0:    c = 32'sd268435456;
                    3'd1:    c = 32'sd536870912;
                    3'd2:    c = 32'sd268435456;
                    3'd3:    c = -32'sd266989206;
                    3'd4:    c = -32'sd162416390;
                    default: c = '0;
                endcase
            end
            2'd2:
            begin
                unique case (k)
                    3'd0:    c = 32'sd268435456;
                    3'd1:    c = -32'sd536870912;
                    3'd2:    c = 32'sd268435456;
                    3'd3:    c = 32'sd494312725;
                    3'd4:    c = -32'sd236356050;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Saturate a 64-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == {33{v[63]}})
            r = v[31:0];
        else if (v[63])
            r = INT32_MIN;
        else
            r = INT32_MAX;
        return r;
    endfunction

    // Round half up, shift right by 28, saturate to 32 bits
    function automatic logic signed [31:0] rnd_sat32(input logic signed [63:0] v);
        logic signed [63:0] u;
        logic signed [35:0] q;
        logic signed [31:0] r;
        u = v + ROUND_HALF_Q28;
        q = u[63:28];
        if (q[35:31] == {5{q[35]}})
            r = q[31:0];
        else if (q[35])
            r = INT32_MIN;
        else
            r = INT32_MAX;
        return r;
    endfunction

endpackage

// ----- rtl/fm_rx_audio_unpack_filter.sv -----
// FM receive audio unpacker: two offset-binary samples per item, rx gain,
// de-emphasis and a biquad band-pass cascade on one shared multiplier.
// Each sample passes the rx gain, the optional de-emphasis and STAGES biquad sections
// in turn; a new item is accepted only after both samples of the last one have been
// handed to the output register, since the single MAC unit is shared.
// Reset: async active low; clears filter history, rx_gain to 4096, de-emphasis on.
module fm_rx_audio_unpack_filter
#(
    parameter int SAMPLE_BITS = 12,
    parameter int STAGES      = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input item stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // [2*SAMPLE_BITS-1:0] packed_group
    input  logic                 s_tlast,                 // block_end
    // Result item stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,                 // [15:0] audio_sample
    output logic                 m_tlast,                 // second_of_pair
    output logic                 m_tuser,                 // frame_end
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    localparam int GROUP_W = 2 * SAMPLE_BITS;
    localparam int SW      = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic signed [32:0] OUT_HALF = 33'sd1 <<< (SAMPLE_BITS - 2);
    localparam logic signed [32:0] OUT_MAX  = 33'sd32767;
    localparam logic signed [32:0] OUT_MIN  = -33'sd32768;

    // Configuration
    logic [15:0] rx_gain_reg;
    logic        deemph_en_reg;

    // Sequencer and working registers
    fmrx_pkg::seq_state_t state_reg, state_next;
    logic [GROUP_W-1:0]   group_reg, group_next;
    logic                 block_end_reg, block_end_next;
    logic                 half_reg, half_next;
    logic                 is_de_reg, is_de_next;
    logic [SW-1:0]        stage_reg, stage_next;
    logic [1:0]           row_reg, row_next;
    logic [2:0]           term_reg, term_next;
    logic signed [31:0]   x_reg, x_next;
    logic signed [31:0]   raw_reg, raw_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_user_reg, out_user_next;

    // Filter history
    logic signed [31:0]   de_x_reg;
    logic signed [31:0]   de_y_reg;
    logic signed [31:0]   bq_x1_reg [STAGES];
    logic signed [31:0]   bq_x2_reg [STAGES];
    logic signed [31:0]   bq_y1_reg [STAGES];
    logic signed [31:0]   bq_y2_reg [STAGES];
    logic                 hist_we;

    // MAC unit connections
    fmrx_pkg::mac_ctrl_t  mac_ctrl;
    logic signed [31:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic signed [31:0]   prod_sat;
    logic signed [31:0]   prod_rnd;
    logic signed [31:0]   acc_rnd;

    // Sample and output helpers
    logic [SAMPLE_BITS-1:0]        code;
    logic signed [SAMPLE_BITS-1:0] centred;
    logic [2:0]                    last_term;
    logic signed [31:0]            hist_op;
    logic signed [32:0]            out_sum;
    logic signed [32:0]            out_q;
    logic [15:0]                   out_sample;

    fmrx_mac u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_sat (prod_sat),
        .prod_rnd (prod_rnd),
        .acc_rnd  (acc_rnd)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_gain_reg   <= fmrx_pkg::RX_GAIN_RESET;
            deemph_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmrx_pkg::CFG_RX_GAIN:   rx_gain_reg   <= cfg_wdata;
                fmrx_pkg::CFG_DEEMPH_EN: deemph_en_reg <= cfg_wdata[0];
                default:                 rx_gain_reg   <= rx_gain_reg;
            endcase
        end
    end

    // Pick the current sample; offset binary to two's complement flips the MSB
    assign code    = half_reg ? group_reg[SAMPLE_BITS-1:0]
                              : group_reg[GROUP_W-1:SAMPLE_BITS];
    assign centred = {~code[SAMPLE_BITS-1], code[SAMPLE_BITS-2:0]};

    assign last_term = is_de_reg ? 3'(fmrx_pkg::DE_TERMS - 1)
                                 : 3'(fmrx_pkg::BQ_TERMS - 1);

    // Select the history operand for the current term
    always_comb
    begin
        hist_op = x_reg;
        if (is_de_reg)
        begin
            unique case (term_reg)
                3'd1:    hist_op = de_x_reg;
                3'd2:    hist_op = de_y_reg;
                default: hist_op = x_reg;
            endcase
        end
        else
        begin
            unique case (term_reg)
                3'd1:    hist_op = bq_x1_reg[stage_reg];
                3'd2:    hist_op = bq_x2_reg[stage_reg];
                3'd3:    hist_op = bq_y1_reg[stage_reg];
                3'd4:    hist_op = bq_y2_reg[stage_reg];
                default: hist_op = x_reg;
            endcase
        end
    end

    // Round the chain output to Q3.12 and saturate
    assign out_sum = 33'(x_reg) + OUT_HALF;
    assign out_q   = out_sum >>> (SAMPLE_BITS - 1);
    always_comb
    begin
        if (out_q > OUT_MAX)
            out_sample = 16'h7FFF;
        else if (out_q < OUT_MIN)
            out_sample = 16'h8000;
        else
            out_sample = out_q[15:0];
    end

    // Sequencer: next state, operands and register updates
    always_comb
    begin
        state_next     = state_reg;
        group_next     = group_reg;
        block_end_next = block_end_reg;
        half_next      = half_reg;
        is_de_next     = is_de_reg;
        stage_next     = stage_reg;
        row_next       = row_reg;
        term_next      = term_reg;
        x_next         = x_reg;
        raw_next       = raw_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        s_tready       = 1'b0;
        hist_we        = 1'b0;
        mac_ctrl       = '0;
        mul_a          = x_reg;
        mul_b          = '0;

        unique case (state_reg)
            fmrx_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    group_next     = s_tdata[GROUP_W-1:0];
                    block_end_next = s_tlast;
                    half_next      = 1'b0;
                    state_next     = fmrx_pkg::ST_GAIN_MUL;
                end
            end

            // Scale the centred sample by rx_gain
            fmrx_pkg::ST_GAIN_MUL:
            begin
                mul_a           = 32'(centred);
                mul_b           = signed'({16'd0, rx_gain_reg});
                mac_ctrl.mul_en = 1'b1;
                state_next      = fmrx_pkg::ST_GAIN_SAT;
            end

            fmrx_pkg::ST_GAIN_SAT:
            begin
                x_next     = prod_sat;
                is_de_next = deemph_en_reg;
                stage_next = '0;
                row_next   = '0;
                term_next  = '0;
                state_next = fmrx_pkg::ST_MAC;
            end

            // Issue one coefficient-times-history term per cycle
            fmrx_pkg::ST_MAC:
            begin
                mul_a             = hist_op;
                mul_b             = is_de_reg ? fmrx_pkg::de_coef(term_reg)
                                              : fmrx_pkg::bq_coef(row_reg, term_reg);
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.acc_en   = 1'b1;
                mac_ctrl.acc_load = (term_reg == 3'd0);
                if (term_reg == last_term)
                begin
                    term_next  = '0;
                    state_next = fmrx_pkg::ST_DRAIN;
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                end
            end

            // Let the last product reach the accumulator
            fmrx_pkg::ST_DRAIN:
            begin
                state_next = fmrx_pkg::ST_ROUND;
            end

            fmrx_pkg::ST_ROUND:
            begin
                raw_next   = acc_rnd;
                state_next = fmrx_pkg::ST_SCALE_MUL;
            end

            // Apply the section gain and shift the history
            fmrx_pkg::ST_SCALE_MUL:
            begin
                mul_a           = raw_reg;
                mul_b           = is_de_reg ? fmrx_pkg::DEEMPH_GAIN : fmrx_pkg::STAGE_GAIN;
                mac_ctrl.mul_en = 1'b1;
                hist_we         = 1'b1;
                state_next      = fmrx_pkg::ST_SCALE_SAT;
            end

            fmrx_pkg::ST_SCALE_SAT:
            begin
                x_next = prod_rnd;
                if (is_de_reg)
                begin
                    is_de_next = 1'b0;
                    state_next = fmrx_pkg::ST_MAC;
                end
                else if (stage_reg == SW'(STAGES - 1))
                begin
                    state_next = fmrx_pkg::ST_OUT;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    row_next   = (row_reg == 2'(fmrx_pkg::BQ_ROWS - 1)) ? 2'd0
                                                                        : row_reg + 2'd1;
                    state_next = fmrx_pkg::ST_MAC;
                end
            end

            // Hand the sample to the output register once it is free
            fmrx_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = out_sample;
                    out_last_next  = half_reg;
                    out_user_next  = half_reg & block_end_reg;
                    if (half_reg)
                    begin
                        state_next = fmrx_pkg::ST_IDLE;
                    end
                    else
                    begin
                        half_next  = 1'b1;
                        state_next = fmrx_pkg::ST_GAIN_MUL;
                    end
                end
            end

            default:
            begin
                state_next = fmrx_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmrx_pkg::ST_IDLE;
            half_reg      <= 1'b0;
            is_de_reg     <= 1'b0;
            stage_reg     <= '0;
            row_reg       <= '0;
            term_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            half_reg      <= half_next;
            is_de_reg     <= is_de_next;
            stage_reg     <= stage_next;
            row_reg       <= row_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        group_reg     <= group_next;
        block_end_reg <= block_end_next;
        x_reg         <= x_next;
        raw_reg       <= raw_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_user_reg  <= out_user_next;
    end

    // Filter history: shift in the section input and raw output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            de_x_reg <= '0;
            de_y_reg <= '0;
            for (int i = 0; i < STAGES; i++)
            begin
                bq_x1_reg[i] <= '0;
                bq_x2_reg[i] <= '0;
                bq_y1_reg[i] <= '0;
                bq_y2_reg[i] <= '0;
            end
        end
        else if (hist_we)
        begin
            if (is_de_reg)
            begin
                de_x_reg <= x_reg;
                de_y_reg <= raw_reg;
            end
            else
            begin
                bq_x2_reg[stage_reg] <= bq_x1_reg[stage_reg];
                bq_x1_reg[stage_reg] <= x_reg;
                bq_y2_reg[stage_reg] <= bq_y1_reg[stage_reg];
                bq_y1_reg[stage_reg] <= raw_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- rtl/fmrx_mac.sv -----
// Shared multiply-accumulate unit: registered 32x32 product, 64-bit accumulator
// and the rounding/saturation taps read by the sequencer. Depends on fmrx_pkg.
module fmrx_mac
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fmrx_pkg::mac_ctrl_t   ctrl,
    input  logic signed [31:0]    op_a,
    input  logic signed [31:0]    op_b,
    output logic signed [31:0]    prod_sat,
    output logic signed [31:0]    prod_rnd,
    output logic signed [31:0]    acc_rnd
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic               acc_en_reg;
    logic               acc_load_reg;

    // Multiply, then fold the held product into the accumulator in the following cycle
    always_comb
    begin
        prod_next = ctrl.mul_en ? op_a * op_b : prod_reg;
        acc_next  = acc_reg;
        if (acc_en_reg)
        begin
            if (acc_load_reg)
                acc_next = prod_reg;
            else
                acc_next = acc_reg + prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg   <= 1'b0;
            acc_load_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg   <= ctrl.acc_en;
            acc_load_reg <= ctrl.acc_load;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Result taps
    assign prod_sat = fmrx_pkg::sat32(prod_reg);
    assign prod_rnd = fmrx_pkg::rnd_sat32(prod_reg);
    assign acc_rnd  = fmrx_pkg::rnd_sat32(acc_reg);

endmodule
